[sv/uvs_pkg.sv]
package uvs_pkg;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_COLUMNS        = 2'd0,
        REG_ROWS           = 2'd1,
        REG_LONGITUDE_STEP = 2'd2,
        REG_LATITUDE_STEP  = 2'd3
    } cfg_reg_t;

    // Position inside the strip: which vertex comes next
    typedef enum logic [1:0] {
        STRIP_CUR        = 2'd0,   // (u, v)
        STRIP_NXT        = 2'd1,   // (u, v of next row edge)
        STRIP_STITCH_CUR = 2'd2,   // (1, v)
        STRIP_STITCH_NXT = 2'd3    // (0, v of next row edge)
    } strip_phase_t;

    // Register reset values
    localparam int unsigned COLUMNS_RESET        = 50;
    localparam int unsigned ROWS_RESET           = 100;
    localparam int unsigned LONGITUDE_STEP_RESET = 1311;
    localparam int unsigned LATITUDE_STEP_RESET  = 655;

    // u and v are unsigned 1.16, phases are 17-bit turns
    localparam logic [16:0] UNIT_ONE   = 17'h10000;
    localparam logic [16:0] PH_QUARTER = 17'h08000;
    localparam logic [16:0] PH_SOUTH   = 17'h18000;   // minus a quarter turn

    typedef struct packed {
        logic advance;
        logic restart;
    } req_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               row_end;
        logic               mesh_end;
    } vtx_item_t;

endpackage

[sv/uvs_if.sv]
interface uvs_req_if;
    import uvs_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uvs_vtx_if;
    import uvs_pkg::*;

    logic      valid;
    logic      ready;
    vtx_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/uv_sphere_strip_generator_unit.sv]
// Unit-sphere vertex generator in triangle-strip order. Each request transaction with
// advance set yields one vertex transaction (x, y, z in signed fixed point with
// OUT_FRAC_BITS fraction bits, plus row_end and mesh_end flags); restart first returns
// the walk to the first vertex, and a request without advance yields nothing. The block
// takes one request per cycle and delivers one vertex per cycle while the vertex output
// is not stalled; each vertex passes through three register stages after its request is
// taken: sine table read, multiply, round and register.
// The pace is set by the walk counters, which advance once per request with advance
// set, and by the quarter-wave sine tables: two read-only copies, each read at two
// addresses per cycle (longitude cos/sin, latitude cos/sin). The tables are built at
// elaboration, so there is no fill or clearing pass after reset. Write the configuration
// registers only while no vertex is in flight.
module uv_sphere_strip_generator_unit #(
    parameter int COUNT_BITS       = 8,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int OUT_FRAC_BITS    = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    uvs_req_if.sink           req,
    uvs_vtx_if.source         vtx,
    input  logic              write_enable,
    input  uvs_pkg::cfg_reg_t write_index,
    input  logic [15:0]       write_data
);
    import uvs_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);   // table index
    localparam int TW = OUT_FRAC_BITS + 1;              // table entry, up to 1.0
    localparam int PW = 2 * TW;                         // product of two entries
    localparam int MW = OUT_FRAC_BITS + 2;              // rounded magnitude
    localparam int EW = (MW > 16) ? MW : 16;            // signed result before cut
    localparam int AW = 16 + IW;                        // index arithmetic
    localparam int CW = COUNT_BITS + 1;                 // column index

    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
    localparam logic [63:0] SERIES_DIV [14] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    typedef logic [TW-1:0] rom_t [SINE_TABLE_DEPTH+1];

    typedef struct packed {
        logic          neg;
        logic [IW-1:0] idx;
    } look_t;

    // Quarter-wave sine, rounded to OUT_FRAC_BITS, from a Q60 Taylor series
    function automatic rom_t build_rom();
        rom_t         t;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  e;
        logic [127:0] p;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x = (HALF_PI_Q60 / SINE_TABLE_DEPTH) * 64'(k)
              + ((HALF_PI_Q60 % SINE_TABLE_DEPTH) * 64'(k)) / SINE_TABLE_DEPTH;
            p = {64'd0, x} * {64'd0, x};
            x2 = p[123:60];
            term = x;
            sum = x;
            for (int n = 1; n <= 14; n++)
            begin
                p = {64'd0, term} * {64'd0, x2};
                term = p[123:60] / SERIES_DIV[n-1];
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            e = (sum + (64'd1 << (59 - OUT_FRAC_BITS))) >> (60 - OUT_FRAC_BITS);
            if (e > (64'd1 << OUT_FRAC_BITS))
                e = 64'd1 << OUT_FRAC_BITS;
            t[k] = e[TW-1:0];
        end
        return t;
    endfunction

    localparam rom_t THETA_ROM = build_rom();
    localparam rom_t PHI_ROM   = build_rom();

    // Map a 17-bit phase to a table index and a sign by quadrant symmetry
    function automatic look_t phase_look(logic [16:0] p);
        look_t         res;
        logic [15:0]   arg;
        logic [AW-1:0] scaled;
        arg = p[15] ? 16'(PH_QUARTER - {2'b00, p[14:0]}) : {1'b0, p[14:0]};
        scaled = AW'(arg) * AW'(SINE_TABLE_DEPTH) + AW'(PH_QUARTER >> 1);
        res.idx = scaled[15 +: IW];
        res.neg = p[16];
        return res;
    endfunction

    // Apply sign and cut to the 16-bit output field
    function automatic logic signed [15:0] signed_out(logic [MW-1:0] mag, logic neg);
        logic [EW-1:0] ext;
        logic [EW-1:0] val;
        ext = EW'(mag);
        val = neg ? (~ext + EW'(1)) : ext;
        return val[15:0];
    endfunction

    // Configuration registers
    logic [COUNT_BITS-1:0] columns_reg;
    logic [COUNT_BITS-1:0] rows_reg;
    logic [15:0]           longitude_step_reg;
    logic [15:0]           latitude_step_reg;

    // Walk state
    logic [COUNT_BITS-1:0] row_index_reg, row_index_next;
    logic [CW-1:0]         column_index_reg, column_index_next;
    strip_phase_t          strip_phase_reg, strip_phase_next;
    logic [16:0]           longitude_phase_reg, longitude_phase_next;
    logic [16:0]           latitude_fraction_reg, latitude_fraction_next;

    // Walk decode
    logic [COUNT_BITS-1:0] row_cur;
    logic [CW-1:0]         col_cur;
    strip_phase_t          phase_cur;
    logic [16:0]           lon_cur;
    logic [16:0]           lat_cur;
    logic                  last_row;
    logic                  last_col;
    logic [16:0]           v_cur;
    logic [16:0]           v_nxt;
    logic [17:0]           v_sum;
    logic [17:0]           u_sum;
    logic [16:0]           u_cur;

    // Vertex selection
    logic [16:0] u_emit;
    logic [16:0] v_emit;
    logic        row_end_emit;
    logic        mesh_end_emit;
    logic [16:0] theta;
    logic [16:0] phi;
    look_t       ct_look, st_look, cp_look, sp_look;

    // Pipeline
    logic accept;
    logic en1, en2, en3;

    logic          s1_valid_reg;
    logic [TW-1:0] s1_ct_reg, s1_st_reg, s1_cp_reg, s1_sp_reg;
    logic          s1_ct_neg_reg, s1_st_neg_reg, s1_cp_neg_reg, s1_sp_neg_reg;
    logic          s1_row_end_reg, s1_mesh_end_reg;

    logic          s2_valid_reg;
    logic [PW-1:0] s2_x_prod_reg, s2_y_prod_reg;
    logic          s2_x_neg_reg, s2_y_neg_reg;
    logic [TW-1:0] s2_z_mag_reg;
    logic          s2_z_neg_reg;
    logic          s2_row_end_reg, s2_mesh_end_reg;

    logic          out_valid_reg;
    vtx_item_t     out_data_reg;

    logic [PW-1:0] x_round, y_round;

    // Handshake: each stage moves when the one after it is empty or moving
    assign en3    = !out_valid_reg || vtx.ready;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;
    assign accept = req.valid && req.ready;

    assign req.ready = en1;
    assign vtx.valid = out_valid_reg;
    assign vtx.data  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg        <= COUNT_BITS'(COLUMNS_RESET);
            rows_reg           <= COUNT_BITS'(ROWS_RESET);
            longitude_step_reg <= 16'(LONGITUDE_STEP_RESET);
            latitude_step_reg  <= 16'(LATITUDE_STEP_RESET);
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_COLUMNS:        columns_reg        <= write_data[COUNT_BITS-1:0];
                REG_ROWS:           rows_reg           <= write_data[COUNT_BITS-1:0];
                REG_LONGITUDE_STEP: longitude_step_reg <= write_data;
                REG_LATITUDE_STEP:  latitude_step_reg  <= write_data;
                default:            ;
            endcase
        end
    end

    // Decode the walk position, with restart applied first
    always_comb
    begin
        if (req.data.restart)
        begin
            row_cur   = '0;
            col_cur   = '0;
            phase_cur = STRIP_CUR;
            lon_cur   = '0;
            lat_cur   = '0;
        end
        else
        begin
            row_cur   = row_index_reg;
            col_cur   = column_index_reg;
            phase_cur = strip_phase_reg;
            lon_cur   = longitude_phase_reg;
            lat_cur   = latitude_fraction_reg;
        end
        last_row = ({1'b0, row_cur} + CW'(1)) >= {1'b0, rows_reg};
        last_col = col_cur >= {1'b0, columns_reg};
        v_cur    = (lat_cur > UNIT_ONE) ? UNIT_ONE : lat_cur;
        v_sum    = {1'b0, v_cur} + {2'b00, latitude_step_reg};
        if (last_row || v_sum > {1'b0, UNIT_ONE})
            v_nxt = UNIT_ONE;
        else
            v_nxt = v_sum[16:0];
        u_sum = {1'b0, lon_cur} + {2'b00, longitude_step_reg};
        u_cur = last_col ? UNIT_ONE : lon_cur;
    end

    // Next walk state
    always_comb
    begin
        row_index_next         = row_cur;
        column_index_next      = col_cur;
        strip_phase_next       = phase_cur;
        longitude_phase_next   = lon_cur;
        latitude_fraction_next = lat_cur;
        if (req.data.advance)
        begin
            case (phase_cur)
                STRIP_CUR:
                begin
                    strip_phase_next = STRIP_NXT;
                end
                STRIP_NXT:
                begin
                    if (last_col)
                        strip_phase_next = STRIP_STITCH_CUR;
                    else
                    begin
                        column_index_next    = col_cur + CW'(1);
                        longitude_phase_next = (u_sum > {1'b0, UNIT_ONE}) ?
                                               UNIT_ONE : u_sum[16:0];
                        strip_phase_next     = STRIP_CUR;
                    end
                end
                STRIP_STITCH_CUR:
                begin
                    strip_phase_next = STRIP_STITCH_NXT;
                end
                default:
                begin
                    column_index_next    = '0;
                    longitude_phase_next = '0;
                    strip_phase_next     = STRIP_CUR;
                    if (last_row)
                    begin
                        row_index_next         = '0;
                        latitude_fraction_next = '0;
                    end
                    else
                    begin
                        row_index_next         = row_cur + COUNT_BITS'(1);
                        latitude_fraction_next = v_nxt;
                    end
                end
            endcase
        end
    end

    // Vertex chosen by the strip position
    always_comb
    begin
        row_end_emit  = 1'b0;
        mesh_end_emit = 1'b0;
        case (phase_cur)
            STRIP_CUR:
            begin
                u_emit = u_cur;
                v_emit = v_cur;
            end
            STRIP_NXT:
            begin
                u_emit = u_cur;
                v_emit = v_nxt;
            end
            STRIP_STITCH_CUR:
            begin
                u_emit = UNIT_ONE;
                v_emit = v_cur;
            end
            default:
            begin
                u_emit        = '0;
                v_emit        = v_nxt;
                row_end_emit  = 1'b1;
                mesh_end_emit = last_row;
            end
        endcase
    end

    // Angles and table addresses
    assign theta   = {u_emit[15:0], 1'b0};
    assign phi     = v_emit + PH_SOUTH;
    assign ct_look = phase_look(theta + PH_QUARTER);
    assign st_look = phase_look(theta);
    assign cp_look = phase_look(phi + PH_QUARTER);
    assign sp_look = phase_look(phi);

    // Walk state update on every request transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg         <= '0;
            column_index_reg      <= '0;
            strip_phase_reg       <= STRIP_CUR;
            longitude_phase_reg   <= '0;
            latitude_fraction_reg <= '0;
        end
        else if (accept)
        begin
            row_index_reg         <= row_index_next;
            column_index_reg      <= column_index_next;
            strip_phase_reg       <= strip_phase_next;
            longitude_phase_reg   <= longitude_phase_next;
            latitude_fraction_reg <= latitude_fraction_next;
        end
    end

    // Stage 1: sine table reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= accept && req.data.advance;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ct_reg       <= THETA_ROM[ct_look.idx];
            s1_st_reg       <= THETA_ROM[st_look.idx];
            s1_cp_reg       <= PHI_ROM[cp_look.idx];
            s1_sp_reg       <= PHI_ROM[sp_look.idx];
            s1_ct_neg_reg   <= ct_look.neg;
            s1_st_neg_reg   <= st_look.neg;
            s1_cp_neg_reg   <= cp_look.neg;
            s1_sp_neg_reg   <= sp_look.neg;
            s1_row_end_reg  <= row_end_emit;
            s1_mesh_end_reg <= mesh_end_emit;
        end
    end

    // Stage 2: magnitude products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_x_prod_reg   <= PW'(s1_ct_reg) * PW'(s1_cp_reg);
            s2_y_prod_reg   <= PW'(s1_st_reg) * PW'(s1_cp_reg);
            s2_x_neg_reg    <= s1_ct_neg_reg ^ s1_cp_neg_reg;
            s2_y_neg_reg    <= s1_st_neg_reg ^ s1_cp_neg_reg;
            s2_z_mag_reg    <= s1_sp_reg;
            s2_z_neg_reg    <= s1_sp_neg_reg;
            s2_row_end_reg  <= s1_row_end_reg;
            s2_mesh_end_reg <= s1_mesh_end_reg;
        end
    end

    // Round half away from zero: add half an output step to the magnitude
    assign x_round = s2_x_prod_reg + (PW'(1) << (OUT_FRAC_BITS - 1));
    assign y_round = s2_y_prod_reg + (PW'(1) << (OUT_FRAC_BITS - 1));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en3)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            out_data_reg.pos_x    <= signed_out(x_round[OUT_FRAC_BITS +: MW], s2_x_neg_reg);
            out_data_reg.pos_y    <= signed_out(y_round[OUT_FRAC_BITS +: MW], s2_y_neg_reg);
            out_data_reg.pos_z    <= signed_out(MW'(s2_z_mag_reg), s2_z_neg_reg);
            out_data_reg.row_end  <= s2_row_end_reg;
            out_data_reg.mesh_end <= s2_mesh_end_reg;
        end
    end

endmodule
